@@ hdl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the integer literal scanner.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam logic [2:0] RADIX_BIN = 3'd0;
  localparam logic [2:0] RADIX_OCT = 3'd1;
  localparam logic [2:0] RADIX_DEC = 3'd2;
  localparam logic [2:0] RADIX_DOZ = 3'd3;
  localparam logic [2:0] RADIX_HEX = 3'd4;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_PREFIX_DIGIT = 2'd1;
  localparam logic [1:0] ERR_SUFFIX       = 2'd2;

  typedef struct packed {
    logic [63:0] value;
    logic        is_long;
    logic        is_unsigned;
    logic [2:0]  radix_code;
    logic        too_big;
    logic [1:0]  error_code;
  } ils_result_t;

endpackage

@@ hdl/ils_core.sv @@
// ----------------------------------------------------------------------------
// ils_core
// Literal scanner state and the per-character step: prefix decode, digit
// accumulate, suffix count and result formatting.
// ----------------------------------------------------------------------------
module ils_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          ch,
  output logic                emit,
  output ils_pkg::ils_result_t result
);
  import ils_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_ZERO, PH_DIGITS, PH_SUFFIX} phase_t;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LO = 8'h6f;
  localparam logic [7:0] CH_LZ = 8'h7a;
  localparam logic [7:0] CH_LX = 8'h78;
  localparam logic [7:0] CH_LL = 8'h6c;
  localparam logic [7:0] CH_UL = 8'h4c;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UU = 8'h55;

  phase_t      phase, phase_next;
  logic [2:0]  radix, radix_next;
  logic [63:0] acc, acc_next;
  logic [1:0]  lcnt, lcnt_next;
  logic [1:0]  ucnt, ucnt_next;
  logic        go;
  logic        is_dec, is_hex;
  logic [3:0]  dval;

  function automatic logic [63:0] acc_scale(input logic [63:0] a, input logic [2:0] rx);
    logic [63:0] r;
    unique case (rx)
      RADIX_BIN: r = {a[62:0], 1'b0};
      RADIX_OCT: r = {a[60:0], 3'b0};
      RADIX_DOZ: r = {a[60:0], 3'b0} + {a[61:0], 2'b0};
      RADIX_HEX: r = {a[59:0], 4'b0};
      default:   r = {a[60:0], 3'b0} + {a[62:0], 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic digit_fits(input logic [3:0] v, input logic [2:0] rx);
    logic ok;
    unique case (rx)
      RADIX_BIN: ok = (v < 4'd2);
      RADIX_OCT: ok = (v < 4'd8);
      RADIX_DOZ: ok = (v < 4'd12);
      RADIX_HEX: ok = 1'b1;
      default:   ok = (v < 4'd10);
    endcase
    return ok;
  endfunction

  function automatic ils_result_t finish_item(input logic [63:0] num, input logic [1:0] lc,
                                              input logic [1:0] uc, input logic [2:0] rx);
    ils_result_t r;
    r.value       = num;
    r.is_long     = (lc != 2'd0);
    r.is_unsigned = (uc != 2'd0);
    r.radix_code  = rx;
    r.too_big     = 1'b0;
    r.error_code  = (lc == 2'd3 || uc >= 2'd2) ? ERR_SUFFIX : ERR_NONE;
    if (lc == 2'd0) begin
      if (uc != 2'd0) begin
        r.too_big = |num[63:32];
        r.value   = {32'b0, num[31:0]};
      end else begin
        // in range only when bits 63..31 all agree
        r.too_big = !(&num[63:31] || ~|num[63:31]);
        r.value   = {{32{num[31]}}, num[31:0]};
      end
    end
    return r;
  endfunction

  assign is_dec = (ch >= CH_0) && (ch <= CH_9);
  assign is_hex = is_dec || ((ch >= CH_LA) && (ch <= CH_LF)) || ((ch >= CH_UA) && (ch <= CH_UF));
  assign dval   = is_dec ? ch[3:0] : ch[3:0] + 4'd9;

  always_comb begin
    phase_next = phase;
    radix_next = radix;
    acc_next   = acc;
    lcnt_next  = lcnt;
    ucnt_next  = ucnt;
    emit       = 1'b0;
    go         = 1'b1;
    result     = finish_item(acc, lcnt, ucnt, radix);

    // prefix after a leading zero
    if (phase == PH_ZERO) begin
      go = 1'b0;
      phase_next = PH_DIGITS;
      priority if (ch == CH_LB) begin
        radix_next = RADIX_BIN;
      end else if (ch == CH_LO) begin
        radix_next = RADIX_OCT;
      end else if (ch == CH_LZ) begin
        radix_next = RADIX_DOZ;
      end else if (ch == CH_LX) begin
        radix_next = RADIX_HEX;
      end else if (ch >= CH_1 && ch <= CH_7) begin
        radix_next = RADIX_OCT;
        acc_next   = {60'b0, ch[3:0]};
      end else if (is_dec && ch > CH_7) begin
        emit       = 1'b1;
        result     = '{value: 64'd0, is_long: 1'b0, is_unsigned: 1'b0,
                       radix_code: RADIX_OCT, too_big: 1'b0, error_code: ERR_PREFIX_DIGIT};
        phase_next = PH_IDLE;
        radix_next = RADIX_DEC;
        acc_next   = 64'd0;
      end else begin
        radix_next = RADIX_DEC;
        go         = 1'b1;
      end
    end

    if (go && phase_next == PH_DIGITS) begin
      if (is_hex && digit_fits(dval, radix_next)) begin
        acc_next = acc_scale(acc_next, radix_next) + {60'b0, dval};
        go       = 1'b0;
      end else begin
        phase_next = PH_SUFFIX;
      end
    end

    if (go && phase_next == PH_SUFFIX) begin
      if (ch == CH_LL || ch == CH_UL) begin
        if (lcnt_next != 2'd3) lcnt_next = lcnt_next + 2'd1;
        go = 1'b0;
      end else if (ch == CH_LU || ch == CH_UU) begin
        if (ucnt_next != 2'd3) ucnt_next = ucnt_next + 2'd1;
        go = 1'b0;
      end else begin
        emit       = 1'b1;
        result     = finish_item(acc_next, lcnt_next, ucnt_next, radix_next);
        phase_next = PH_IDLE;
        radix_next = RADIX_DEC;
        acc_next   = 64'd0;
        lcnt_next  = 2'd0;
        ucnt_next  = 2'd0;
      end
    end

    // the ending character may start the next literal
    if (go && phase_next == PH_IDLE && is_dec) begin
      radix_next = RADIX_DEC;
      lcnt_next  = 2'd0;
      ucnt_next  = 2'd0;
      acc_next   = {60'b0, ch[3:0]};
      phase_next = (ch == CH_0) ? PH_ZERO : PH_DIGITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      radix <= RADIX_DEC;
      acc   <= 64'd0;
      lcnt  <= 2'd0;
      ucnt  <= 2'd0;
    end else if (fire) begin
      phase <= phase_next;
      radix <= radix_next;
      acc   <= acc_next;
      lcnt  <= lcnt_next;
      ucnt  <= ucnt_next;
    end
  end

endmodule

@@ hdl/integer_literal_scanner_top.sv @@
// Flow: a character accepted into the input register is stepped when it fires; a
//   literal it ends is registered with that step and then shown on m_tvalid.
// Throughput: one character per cycle, set by the per-character step in ils_core;
//   a character that ends a literal waits while an earlier result is stalled.
// Reset (rst, synchronous): empties the input and result registers and returns
//   the scanner to idle, decimal, zero accumulator, zero suffix counts.
// ----------------------------------------------------------------------------
// integer_literal_scanner_top
// Stream front end: input register, scanner step, result register.
// ----------------------------------------------------------------------------
module integer_literal_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // value
  output logic [7:0]  m_tuser    // is_long, is_unsigned, radix_code[2:0], too_big,
                                 // error_code[1:0]
);
  import ils_pkg::*;

  logic        ch_valid;
  logic [7:0]  ch_q;
  logic        out_valid;
  ils_result_t res_q;
  ils_result_t result;
  logic        emit;
  logic        out_free;
  logic        fire;

  // items that end no literal step even while a result waits
  assign out_free = !out_valid || m_tready;
  assign fire     = ch_valid && (!emit || out_free);
  assign s_tready = !ch_valid || fire;

  ils_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .ch     (ch_q),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) ch_valid <= s_tvalid;
      if (fire && emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) ch_q <= s_tdata;
    if (fire && emit) res_q <= result;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = res_q.value;
  assign m_tuser  = {res_q.error_code, res_q.too_big, res_q.radix_code,
                     res_q.is_unsigned, res_q.is_long};

endmodule

@@ hdl/ils_checker.sv @@
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks on the scanner's result stream.
// ----------------------------------------------------------------------------
module ils_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [7:0]  m_tuser
);
  import ils_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a bad digit after zero gives a fixed, empty octal result
  a_prefix_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[7:6] == ERR_PREFIX_DIGIT |->
      m_tdata == 64'd0 && m_tuser[4:2] == RADIX_OCT && m_tuser[5] == 1'b0 &&
      m_tuser[1:0] == 2'b00)
    else $error("bad prefix digit result malformed");

  // signed int values are sign-extended from bit 31
  a_int_signed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[63:32] == {32{m_tdata[31]}})
    else $error("signed int not sign-extended");

  // unsigned int values fit in 32 bits
  a_int_unsigned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && m_tuser[1] |-> m_tdata[63:32] == 32'd0)
    else $error("unsigned int not zero-extended");

  // long types never warn
  a_long_no_warn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[5])
    else $error("too_big set on long literal");

endmodule

bind integer_literal_scanner_top ils_checker u_ils_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
